// ----- rtl/gbhl_pkg.sv -----
// ----------------------------------------------------------------------------
// gbhl_pkg
// Types and constants shared by the bilinear height-grid lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package gbhl_pkg;

  localparam int INDEX_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 17;
  localparam int OUT_W    = 16;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_MAX  = (1 << CFG_W) - 1;
  localparam int GRID_DEPTH = 1 << INDEX_W;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = 2;
  localparam int QCNT_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [3:0] {
    SEQ_IDLE  = 4'b0001,
    SEQ_WRITE = 4'b0010,
    SEQ_READ  = 4'b0100,
    SEQ_SKIP  = 4'b1000
  } seq_state_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] height;
    logic                    in_range;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/grid_bilinear_height_lookup_top.sv -----
// ----------------------------------------------------------------------------
// grid_bilinear_height_lookup_top
// Height grid in one single-port memory with bilinear point queries.
//
//   Channel   Signals                                   Direction
//   req       req_valid/req_ready, req_type, sample_*,   in
//             x_coord, z_coord
//   rsp       rsp_valid/rsp_ready, height_out, in_range  out
//   cfg       cfg_we, cfg_index, cfg_data                in
//
// A query in range holds the memory port for its four corner reads, one
// per corner, and the next request beat can be taken during its last corner
// read. Writes and out-of-range queries hold the port for a single access.
// Every query's result passes the read tag and the m1, m2 and m3 stages. Up to
// four queries may be outstanding; further request beats stall until
// responses are taken.
// Reset clears control state only; the grid contents are kept.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bilinear_height_lookup_top #(
  parameter int COORD_FRAC_BITS = 8,
  parameter int MAX_COLS        = 256,
  parameter int MAX_ROWS        = 256,
  parameter int HEIGHT_BITS     = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  req_valid,
  output      logic                                  req_ready,
  input  wire logic                                  req_type,
  input  wire logic        [gbhl_pkg::INDEX_W-1:0]   sample_index,
  input  wire logic signed [gbhl_pkg::SAMPLE_W-1:0]  sample_height,
  input  wire logic signed [gbhl_pkg::COORD_W-1:0]   x_coord,
  input  wire logic signed [gbhl_pkg::COORD_W-1:0]   z_coord,
  output      logic                                  rsp_valid,
  input  wire logic                                  rsp_ready,
  output      logic signed [gbhl_pkg::OUT_W-1:0]     height_out,
  output      logic                                  in_range,
  input  wire logic                                  cfg_we,
  input  wire logic        [gbhl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [gbhl_pkg::CFG_W-1:0]     cfg_data
);

  import gbhl_pkg::*;

  localparam int F    = COORD_FRAC_BITS;
  localparam int H    = HEIGHT_BITS;
  localparam int HW   = H + 1;
  localparam int DW   = H + 1;
  localparam int PW   = DW + F + 1;
  localparam int DW2  = HW + 1;
  localparam int PW2  = DW2 + F + 1;
  localparam int HSW  = HW + 1;
  localparam int SW   = (HSW > OUT_W + 1) ? HSW : OUT_W + 1;
  localparam int WX   = (H > SAMPLE_W) ? H : SAMPLE_W;
  localparam int LW   = CFG_W + F;
  localparam int CW   = (LW > INDEX_W) ? LW : INDEX_W;
  localparam int COLS_CAP = (MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS;
  localparam int ROWS_CAP = (MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS;
  localparam logic signed [SW-1:0] SAT_HI = SW'(OUT_MAX);
  localparam logic signed [SW-1:0] SAT_LO = SW'(OUT_MIN);

  // Configuration registers.
  logic [CFG_W-1:0] grid_cols;
  logic [CFG_W-1:0] grid_rows;

  // Sequencer that owns the memory port.
  seq_state_t         state;
  seq_state_t         state_next;
  logic [1:0]         slot;
  logic [1:0]         slot_next;
  logic [INDEX_W-1:0] q_base;
  logic [CFG_W-1:0]   q_cols;
  logic [H-1:0]       q_wdata;
  logic [F-1:0]       q_sx;
  logic [F-1:0]       q_sz;

  // Read tag, registered alongside the port's read data.
  logic         t_valid;
  logic         t_last;
  logic         t_skip;
  logic [1:0]   t_slot;
  logic [F-1:0] t_sx;
  logic [F-1:0] t_sz;

  logic [H-1:0]        mem [GRID_DEPTH];
  logic signed [H-1:0] rd_data;
  logic signed [H-1:0] ca;
  logic signed [H-1:0] cb;
  logic signed [H-1:0] cc;

  // Interpolation stages.
  logic                 m1_valid;
  logic                 m1_skip;
  logic [F-1:0]         m1_sz;
  logic signed [H-1:0]  m1_a;
  logic signed [H-1:0]  m1_c;
  logic signed [PW-1:0] m1_p0;
  logic signed [PW-1:0] m1_p1;

  logic                 m2_valid;
  logic                 m2_skip;
  logic [F-1:0]         m2_sz;
  logic signed [HW-1:0] m2_h0;
  logic signed [HW-1:0] m2_h1;

  logic                  m3_valid;
  logic                  m3_skip;
  logic signed [HW-1:0]  m3_h0;
  logic signed [PW2-1:0] m3_p2;

  // Response queue and outstanding-query count.
  result_t             rq [QDEPTH];
  logic [QPTR_W-1:0]   rq_wr;
  logic [QPTR_W-1:0]   rq_rd;
  logic [QCNT_W-1:0]   rq_count;
  logic [QCNT_W-1:0]   pending;

  // Request decode.
  logic [CFG_W-1:0]   cols_eff;
  logic [CFG_W-1:0]   rows_eff;
  logic [INDEX_W-1:0] x_pos;
  logic [INDEX_W-1:0] z_pos;
  logic [INDEX_W-1:0] x0;
  logic [INDEX_W-1:0] z0;
  logic [24:0]        zprod;
  logic               hit;
  logic [WX-1:0]      wext;

  logic               seq_done;
  logic               req_fire;
  logic               rsp_fire;
  logic               query_fire;
  logic               port_we;
  logic [INDEX_W-1:0] port_addr;

  logic signed [F:0]     sx_s;
  logic signed [F:0]     sz_s;
  logic signed [DW-1:0]  d_ab;
  logic signed [DW-1:0]  d_cd;
  logic signed [PW-1:0]  p0;
  logic signed [PW-1:0]  p1;
  logic signed [HW-1:0]  h0;
  logic signed [HW-1:0]  h1;
  logic signed [DW2-1:0] d_h;
  logic signed [PW2-1:0] p2;
  logic signed [HSW-1:0] h_fin;
  logic signed [SW-1:0]  h_ext;
  logic signed [OUT_W-1:0] h_sat;
  result_t               rq_in;

  always_comb begin
    cols_eff = (grid_cols > CFG_W'(COLS_CAP)) ? CFG_W'(COLS_CAP) : grid_cols;
    rows_eff = (grid_rows > CFG_W'(ROWS_CAP)) ? CFG_W'(ROWS_CAP) : grid_rows;
    x_pos = x_coord[INDEX_W-1:0];
    z_pos = z_coord[INDEX_W-1:0];
    x0 = x_pos >> F;
    z0 = z_pos >> F;
    zprod = 25'(z0) * 25'(cols_eff);
    hit = (cols_eff >= CFG_W'(2)) && (rows_eff >= CFG_W'(2)) &&
          !x_coord[COORD_W-1] && !z_coord[COORD_W-1] &&
          (CW'(x_pos) < (CW'(cols_eff - CFG_W'(1)) << F)) &&
          (CW'(z_pos) < (CW'(rows_eff - CFG_W'(1)) << F));
    wext = WX'($unsigned(sample_height));
  end

  assign seq_done = (state != SEQ_READ) || (slot == 2'd3);
  assign req_ready = seq_done && (pending < QCNT_W'(QDEPTH));
  assign req_fire = req_valid && req_ready;
  assign query_fire = req_fire && (req_type == REQ_QUERY);
  assign rsp_valid = (rq_count != '0);
  assign rsp_fire = rsp_valid && rsp_ready;

  always_comb begin
    state_next = state;
    slot_next = slot;
    if (req_fire) begin
      slot_next = 2'd0;
      if (req_type == REQ_WRITE) begin
        state_next = SEQ_WRITE;
      end else if (hit) begin
        state_next = SEQ_READ;
      end else begin
        state_next = SEQ_SKIP;
      end
    end else if (seq_done) begin
      state_next = SEQ_IDLE;
    end else begin
      slot_next = slot + 2'd1;
    end
  end

  always_comb begin
    port_we = (state == SEQ_WRITE);
    port_addr = q_base;
    if (slot[0]) begin
      port_addr = port_addr + INDEX_W'(1);
    end
    if (slot[1]) begin
      port_addr = port_addr + INDEX_W'(q_cols);
    end
    if (port_we) begin
      port_addr = q_base;
    end
  end

  always_ff @(posedge clk) begin
    if (port_we) begin
      mem[port_addr] <= q_wdata;
    end else begin
      rd_data <= mem[port_addr];
    end
  end

  always_comb begin
    sx_s = {1'b0, t_sx};
    d_ab = DW'(cb) - DW'(ca);
    d_cd = DW'(rd_data) - DW'(cc);
    p0 = PW'(sx_s) * PW'(d_ab);
    p1 = PW'(sx_s) * PW'(d_cd);

    h0 = HW'(m1_a) + HW'(m1_p0 >>> F);
    h1 = HW'(m1_c) + HW'(m1_p1 >>> F);

    sz_s = {1'b0, m2_sz};
    d_h = DW2'(m2_h1) - DW2'(m2_h0);
    p2 = PW2'(sz_s) * PW2'(d_h);

    h_fin = HSW'(m3_h0) + HSW'(m3_p2 >>> F);
    h_ext = SW'(h_fin);
    if (h_ext > SAT_HI) begin
      h_sat = OUT_W'(OUT_MAX);
    end else if (h_ext < SAT_LO) begin
      h_sat = OUT_W'(OUT_MIN);
    end else begin
      h_sat = h_ext[OUT_W-1:0];
    end
    rq_in.height = m3_skip ? '0 : h_sat;
    rq_in.in_range = !m3_skip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= '0;
      grid_rows <= '0;
      state <= SEQ_IDLE;
      slot <= 2'd0;
      t_valid <= 1'b0;
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
      m3_valid <= 1'b0;
      rq_wr <= '0;
      rq_rd <= '0;
      rq_count <= '0;
      pending <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GRID_COLS: grid_cols <= cfg_data;
          REG_GRID_ROWS: grid_rows <= cfg_data;
          default: ;
        endcase
      end
      state <= state_next;
      slot <= slot_next;
      t_valid <= (state == SEQ_READ) || (state == SEQ_SKIP);
      m1_valid <= t_valid && t_last;
      m2_valid <= m1_valid;
      m3_valid <= m2_valid;
      if (m3_valid) begin
        rq_wr <= rq_wr + QPTR_W'(1);
      end
      if (rsp_fire) begin
        rq_rd <= rq_rd + QPTR_W'(1);
      end
      rq_count <= rq_count + QCNT_W'(m3_valid) - QCNT_W'(rsp_fire);
      pending <= pending + QCNT_W'(query_fire) - QCNT_W'(rsp_fire);
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      q_base <= (req_type == REQ_WRITE) ? sample_index : zprod[INDEX_W-1:0] + x0;
      q_cols <= cols_eff;
      q_wdata <= wext[H-1:0];
      q_sx <= x_pos[F-1:0];
      q_sz <= z_pos[F-1:0];
    end
    t_last <= (state == SEQ_SKIP) || (slot == 2'd3);
    t_skip <= (state == SEQ_SKIP);
    t_slot <= slot;
    t_sx <= q_sx;
    t_sz <= q_sz;
    if (t_valid && !t_skip) begin
      unique case (t_slot)
        2'd0: ca <= rd_data;
        2'd1: cb <= rd_data;
        2'd2: cc <= rd_data;
        default: ;
      endcase
    end
    m1_skip <= t_skip;
    m1_sz <= t_sz;
    m1_a <= ca;
    m1_c <= cc;
    m1_p0 <= p0;
    m1_p1 <= p1;
    m2_skip <= m1_skip;
    m2_sz <= m1_sz;
    m2_h0 <= h0;
    m2_h1 <= h1;
    m3_skip <= m2_skip;
    m3_h0 <= m2_h0;
    m3_p2 <= p2;
    if (m3_valid) begin
      rq[rq_wr] <= rq_in;
    end
  end

  assign height_out = rq[rq_rd].height;
  assign in_range = rq[rq_rd].in_range;

endmodule

`default_nettype wire
